### rtl/core/b2r_pkg.sv
package b2r_pkg;

  // Fixed field widths of the stream words.
  localparam int VALUE_W      = 31;
  localparam int RADIX_W      = 4;
  localparam int DIGIT_W      = 4;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 8;

  // Default width of the value that is converted.
  localparam int VALUE_BITS_DEF = 31;

  // Legal radix range; requests outside it are clamped.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 4'd9;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_OUT
  } b2r_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new value and radix
    logic div_step;  // one restoring division step
    logic pop_init;  // point the pop index at the top of the stack
    logic pop_next;  // move the pop index down one entry
    logic rd_en;     // read the stack at the pop index
  } b2r_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_last;    // this division step finishes a digit
    logic q_zero_next;  // the quotient after this step is zero
    logic idx_zero;     // the pop index points at the least significant digit
  } b2r_sts_t;

endpackage

### rtl/core/b2r_ram.sv
module b2r_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### rtl/core/b2r_dp.sv
module b2r_dp
  import b2r_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  b2r_cmd_t           cmd,
  output b2r_sts_t           sts,
  input  logic [VALUE_W-1:0] value,
  input  logic [RADIX_W-1:0] radix,
  output logic [DIGIT_W-1:0] digit
);

  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int SW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0]         q_r;
  logic [VALUE_BITS-1:0]         q_nxt;
  logic [RADIX_W-1:0]            radix_r;
  logic [RADIX_W-1:0]            radix_clamped;
  logic [DIGIT_W-1:0]            rem_r;
  logic [DIGIT_W:0]              rem_shift;
  logic [DIGIT_W:0]              rem_sub;
  logic                          q_bit;
  logic [DIGIT_W-1:0]            rem_nxt;
  logic [SW-1:0]                 step_r;
  logic [CW-1:0]                 count_r;
  logic [AW-1:0]                 idx_r;
  logic [VALUE_BITS+VALUE_W-1:0] value_ext;

  // Only the low VALUE_BITS bits of the value take part.
  assign value_ext = {{VALUE_BITS{1'b0}}, value};

  // Clamp the requested radix into two through nine.
  always_comb begin
    priority if (radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = radix;
    end
  end

  // One restoring division step: shift the next dividend bit into the
  // remainder and subtract the radix when it fits.
  always_comb begin
    rem_shift = {rem_r, q_r[VALUE_BITS-1]};
    rem_sub   = rem_shift - {1'b0, radix_r};
    q_bit     = (rem_shift >= {1'b0, radix_r});
    rem_nxt   = q_bit ? rem_sub[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
    q_nxt     = {q_r[VALUE_BITS-2:0], q_bit};
  end

  assign sts.step_last   = (step_r == SW'(VALUE_BITS - 1));
  assign sts.q_zero_next = (q_nxt == '0);
  assign sts.idx_zero    = (idx_r == '0);

  // Quotient, remainder, step counter and digit count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r     <= '0;
      count_r <= '0;
      step_r  <= '0;
    end else if (cmd.load) begin
      q_r     <= value_ext[VALUE_BITS-1:0];
      count_r <= '0;
      step_r  <= '0;
    end else if (cmd.div_step) begin
      q_r <= q_nxt;
      if (sts.step_last) begin
        step_r  <= '0;
        count_r <= count_r + CW'(1);
      end else begin
        step_r <= step_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      radix_r <= radix_clamped;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= sts.step_last ? '0 : rem_nxt;
    end
  end

  // Pop index walks from the newest digit down to the first one.
  always_ff @(posedge clk) begin
    if (cmd.pop_init) begin
      idx_r <= count_r[AW-1:0];
    end else if (cmd.pop_next) begin
      idx_r <= idx_r - AW'(1);
    end
  end

  // Digit stack: push on the last step of each division, pop at idx_r.
  b2r_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.div_step & sts.step_last),
    .waddr (count_r[AW-1:0]),
    .wdata (rem_nxt),
    .re    (cmd.rd_en),
    .raddr (idx_r),
    .rdata (digit)
  );

endmodule

### rtl/core/b2r_ctrl.sv
module b2r_ctrl
  import b2r_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  b2r_sts_t sts,
  output b2r_cmd_t cmd
);

  b2r_state_t state_r;
  b2r_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last && sts.q_zero_next) begin
          cmd.pop_init = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.idx_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pop_next = 1'b1;
            state_nxt    = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/binary_to_radix_digits.sv
// Converts an unsigned integer into digits of a radix from two to nine.
// Input channel (in_*): one word carries the value and the radix; a radix
// below two is treated as two and one above nine as nine. Only the low
// VALUE_BITS bits of the value are used.
// Output channel (out_*): one word per digit, most significant first, with
// out_tlast set on the least significant digit. A zero value gives the
// single digit 0.
// Conversion: after a word is accepted, the bit-serial divider makes one
// quotient bit per cycle and runs over all VALUE_BITS bits of the quotient
// for each digit. The digits then leave the stack RAM one at a time, since
// each pop waits on the registered RAM read.
// One word is converted at a time: in_tready is high only while the block
// is idle, and it rises again the cycle after the last digit is taken.
// A stalled receiver holds the current digit steady on out_tdata until
// out_tready is seen. Reset returns the controller to idle and drops any
// word in progress; the digit stack needs no clearing.
module binary_to_radix_digits
  import b2r_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value [30:0], radix [34:31]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // digit [3:0]
  output logic                   out_tlast
);

  b2r_cmd_t           cmd;
  b2r_sts_t           sts;
  logic [DIGIT_W-1:0] digit;

  b2r_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  b2r_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts),
    .value (in_tdata[VALUE_W-1:0]),
    .radix (in_tdata[VALUE_W+RADIX_W-1:VALUE_W]),
    .digit (digit)
  );

  // The digit sits in the low bits; the upper bits pad to a whole byte.
  assign out_tdata = {{(OUT_TDATA_W-DIGIT_W){1'b0}}, digit};
  assign out_tlast = sts.idx_zero;

endmodule

### rtl/core/b2r_chk.sv
module b2r_chk
  import b2r_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // A stalled digit word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled digit word changed");

  // Only one word is in conversion: no input is taken while digits are shown.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while digits are pending");

  // Conversion always takes time: no digit in the cycle after an accept.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("digit appeared right after accept");

  // Every digit is below the largest radix, and the pad bits stay zero.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] <= 4'd8) && (out_tdata[7:4] == 4'd0))
    else $error("digit out of range");

endmodule

bind binary_to_radix_digits b2r_chk u_chk (.*);
